// ===== rtl/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and codes of the circular FIFO queue
// Action and status codes, the cell control group and default sizes.
// ----------------------------------------------------------------------------
package cfq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LIST   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_DELETED   = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_LISTED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	// Control for one cell of the chain.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ===== rtl/cfq_cell.sv =====
// ----------------------------------------------------------------------------
// cfq_cell: one storage cell of the queue chain
// Holds one word; loads a new word or takes its neighbor's word on a shift.
// ----------------------------------------------------------------------------
module cfq_cell (
	input  logic                      clk,
	input  cfq_pkg::cell_ctl_t        ctl,
	input  logic [cfq_pkg::DATA_W-1:0] load_data,
	input  logic [cfq_pkg::DATA_W-1:0] next_data,
	output logic [cfq_pkg::DATA_W-1:0] data
);
	import cfq_pkg::*;

	logic [DATA_W-1:0] data_q;

	// A load takes priority over the shift, so the tail cell can refill during a rotation.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/circular_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue: FIFO queue of unsigned words with insert, delete and list
// Words sit in a chain of cells, the oldest in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) carries one action per item: s_tuser holds the
//   action code, s_tdata the word to insert. The output channel (m_*) carries
//   result items: m_tuser holds the status, m_tdata the word, m_tlast marks
//   the final result of an input item.
//   Inserts and deletes may follow back to back; the result appears on the
//   output register in the cycle after acceptance.
//   A list of N stored words enters the list state, then gives one result
//   per cycle while the receiver takes them, the chain rotating by one cell
//   each time, so that after N steps the words are back in order. No input is
//   taken during a list. An empty queue's list gives one result in the next cycle.
//   When the receiver stalls, the output register holds its item and the
//   block accepts nothing new until that item is taken.
//   Reset empties the queue and the output register; stored words are not
//   cleared, since a word is only read after it was written.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
	parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cfq_pkg::DATA_W-1:0]   s_tdata,  // [31:0] value
	input  logic [cfq_pkg::ACTION_W-1:0] s_tuser,  // [1:0] action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cfq_pkg::DATA_W-1:0]   m_tdata,  // [31:0] data
	output logic [cfq_pkg::STATUS_W-1:0] m_tuser,  // [2:0] status
	output logic                         m_tlast
);
	import cfq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rem_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	status_t           m_tuser_q;
	logic              m_tlast_q;

	logic              out_free;
	logic              in_acc;
	logic              is_full;
	logic              is_empty;
	logic              ins_go;
	logic              del_go;
	logic              rot_go;
	action_t           action;
	logic [DATA_W-1:0] head_data;
	logic [DATA_W-1:0] load_data;
	logic [DATA_W-1:0] cell_data [DEPTH];

	assign action   = action_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign ins_go   = in_acc && (action == ACT_INSERT) && !is_full;
	assign del_go   = in_acc && (action == ACT_DELETE) && !is_empty;
	assign rot_go   = (state_q == S_LIST) && out_free;

	assign head_data = cell_data[0];
	assign load_data = rot_go ? head_data : s_tdata;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t         ctl;
		logic [DATA_W-1:0] next_data;

		// An insert fills the first free cell; a rotation refills the last used one.
		assign ctl.load  = (ins_go && (count_q == CW'(i))) ||
		                   (rot_go && (count_q == CW'(i + 1)));
		assign ctl.shift = del_go || rot_go;

		if (i == DEPTH - 1) begin : g_end
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = cell_data[i + 1];
		end

		cfq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load_data (load_data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ins_go) begin
				count_q <= count_q + CW'(1);
			end else if (del_go) begin
				count_q <= count_q - CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						m_tvalid_q <= (action != ACT_NONE) &&
						              !((action == ACT_LIST) && !is_empty);
						if ((action == ACT_LIST) && !is_empty) begin
							state_q <= S_LIST;
							rem_q   <= count_q;
						end
					end else if (out_free) begin
						m_tvalid_q <= 1'b0;
					end
				end
				S_LIST: begin
					// While listing, a free output register always takes the next word.
					if (rot_go) begin
						m_tvalid_q <= 1'b1;
						rem_q      <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (rot_go) begin
			m_tuser_q <= ST_LISTED;
			m_tdata_q <= head_data;
			m_tlast_q <= (rem_q == CW'(1));
		end else if (in_acc) begin
			m_tlast_q <= 1'b1;
			unique case (action)
				ACT_INSERT: begin
					m_tuser_q <= is_full ? ST_OVERFLOW : ST_INSERTED;
					m_tdata_q <= is_full ? '0 : s_tdata;
				end
				ACT_DELETE: begin
					m_tuser_q <= is_empty ? ST_UNDERFLOW : ST_DELETED;
					m_tdata_q <= is_empty ? '0 : head_data;
				end
				ACT_LIST: begin
					m_tuser_q <= ST_EMPTY;
					m_tdata_q <= '0;
				end
				ACT_NONE: begin
					m_tuser_q <= m_tuser_q;
					m_tdata_q <= m_tdata_q;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/cfq_checker.sv =====
// ----------------------------------------------------------------------------
// cfq_checker: port-level checks of the circular FIFO queue
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cfq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [cfq_pkg::DATA_W-1:0]   s_tdata,
	input logic [cfq_pkg::ACTION_W-1:0] s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cfq_pkg::DATA_W-1:0]   m_tdata,
	input logic [cfq_pkg::STATUS_W-1:0] m_tuser,
	input logic                         m_tlast
);
	import cfq_pkg::*;

	// A stalled output item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// Only listed elements may leave the last marker low.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_LISTED) |-> m_tlast)
		else $error("single result item without last marker");

	// Overflow, underflow and empty results carry zero data.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_OVERFLOW || m_tuser == ST_UNDERFLOW ||
		             m_tuser == ST_EMPTY) |-> (m_tdata == '0))
		else $error("error result with nonzero data");

	// An accepted insert answers in the next cycle with its own word or an overflow.
	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_INSERT) |=>
		m_tvalid && ((m_tuser == ST_INSERTED && m_tdata == $past(s_tdata)) ||
		             m_tuser == ST_OVERFLOW))
		else $error("insert not answered in the next cycle");

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (.*);
